>>> rtl/rrs_pkg.sv
// Shared types and constants for the rectangle range sum block.
// Request and response payloads, field widths and register indexes.
// No dependencies.
`default_nettype none

package rrs_pkg;

	// Field widths
	localparam int unsigned ROW_W  = 6;
	localparam int unsigned COL_W  = 6;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned SUM_W  = 44;
	localparam int unsigned CFG_W  = 7;
	// Width of a row base or linear address before it is cut to the memory index
	localparam int unsigned BASE_W = ROW_W + CFG_W + 1;

	// Default matrix bounds
	localparam int unsigned ROWS_MAX_DEF = 64;
	localparam int unsigned COLS_MAX_DEF = 64;

	// Register reset value
	localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

	// Register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// Request operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                     op;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         col;
		logic [ROW_W-1:0]         row_end;
		logic [COL_W-1:0]         col_end;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] rect_sum;
		logic                    range_error;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/rectangle_range_sum.sv
// Rectangle range sum: matrix held in one synchronous RAM, queries walked
// one entry per cycle with a 44-bit accumulator.
// Depends on rrs_pkg.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------
//  in      | in  | in_valid / in_ready   | rrs_pkg::req_t (write/query)
//  out     | out | out_valid / out_ready | rrs_pkg::rsp_t (query only)
//  cfg     | in  | cfg_we                | cfg_index, cfg_data
//
// A write request completes on acceptance. A query goes through check, walk,
// drain and done; an empty or out-of-range query skips from check to done.
// The walk is paced by the single RAM read port, one entry read per cycle.
// Reset clears control state and sets both dimensions to 64; RAM contents
// are undefined until written. A new request is taken while a result still
// waits on the output; a finished query holds until the output is free.
`default_nettype none

module rectangle_range_sum #(
	parameter int unsigned ROWS_MAX = rrs_pkg::ROWS_MAX_DEF,
	parameter int unsigned COLS_MAX = rrs_pkg::COLS_MAX_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output      logic                      in_ready,
	input  wire rrs_pkg::req_t             in_req,
	output      logic                      out_valid,
	input  wire logic                      out_ready,
	output      rrs_pkg::rsp_t             out_rsp,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [rrs_pkg::CFG_W-1:0] cfg_data
);
	import rrs_pkg::*;

	localparam int unsigned DEPTH  = ROWS_MAX * COLS_MAX;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
	localparam logic [CFG_W-1:0] ROWS_CAP = CFG_W'((ROWS_MAX > CFG_MAX) ? CFG_MAX : ROWS_MAX);
	localparam logic [CFG_W-1:0] COLS_CAP = CFG_W'((COLS_MAX > CFG_MAX) ? CFG_MAX : COLS_MAX);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CFG_W-1:0]   rows_q, cols_q;
	logic [CFG_W-1:0]   nrows, ncols;
	req_t               req_q;
	logic [ROW_W-1:0]   i_q;
	logic [COL_W-1:0]   j_q;
	logic [BASE_W-1:0]  row_base_q;
	logic signed [SUM_W-1:0] sum_q;
	logic               err_q;
	logic               rd_valid_s1;
	logic [DATA_W-1:0]  rd_data_s1;
	logic               out_valid_q;
	rsp_t               out_rsp_q;

	logic [DATA_W-1:0]  mem [DEPTH];
	logic               in_acc;
	logic               mem_we;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [BASE_W-1:0]  wr_lin, rd_lin;
	logic               q_bad, q_empty;
	logic               last_col, last_entry;
	logic               out_free;

	// Clamp the dimensions to 1 .. maximum
	always_comb begin
		priority if (rows_q == '0) begin
			nrows = CFG_W'(1);
		end else if (rows_q > ROWS_CAP) begin
			nrows = ROWS_CAP;
		end else begin
			nrows = rows_q;
		end
		priority if (cols_q == '0) begin
			ncols = CFG_W'(1);
		end else if (cols_q > COLS_CAP) begin
			ncols = COLS_CAP;
		end else begin
			ncols = cols_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;
	assign out_free  = !out_valid_q || out_ready;

	// Write address: row * stride + column, only for entries inside the area
	assign wr_lin  = BASE_W'(in_req.row) * BASE_W'(ncols) + BASE_W'(in_req.col);
	assign wr_addr = ADDR_W'(wr_lin);
	assign mem_we  = in_acc && (in_req.op == OP_WRITE) &&
		(CFG_W'(in_req.row) < nrows) && (CFG_W'(in_req.col) < ncols);

	// Query checks on the held request
	assign q_bad = (CFG_W'(req_q.row) >= nrows) || (CFG_W'(req_q.row_end) >= nrows) ||
		(CFG_W'(req_q.col) >= ncols) || (CFG_W'(req_q.col_end) >= ncols);
	assign q_empty = (req_q.row > req_q.row_end) || (req_q.col > req_q.col_end);

	// Walk position
	assign rd_lin     = row_base_q + BASE_W'(j_q);
	assign rd_addr    = ADDR_W'(rd_lin);
	assign last_col   = (j_q == req_q.col_end);
	assign last_entry = last_col && (i_q == req_q.row_end);

	// Matrix RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= in_req.value;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				default:  rows_q <= rows_q;
			endcase
		end
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= in_req;
		end
	end

	// Sequencer: check, walk the rectangle, drain the last read, hand over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_WALK);
			// Raise the response on hand-over, drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_req.op == OP_QUERY)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (q_bad || q_empty) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (last_entry) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: walk counters, row base and accumulator
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			sum_q      <= '0;
			err_q      <= q_bad;
			i_q        <= req_q.row;
			j_q        <= req_q.col;
			row_base_q <= BASE_W'(req_q.row) * BASE_W'(ncols);
		end else begin
			if (state_q == ST_WALK) begin
				if (last_col) begin
					j_q        <= req_q.col;
					i_q        <= i_q + ROW_W'(1);
					row_base_q <= row_base_q + BASE_W'(ncols);
				end else begin
					j_q <= j_q + COL_W'(1);
				end
			end
			if (rd_valid_s1) begin
				sum_q <= sum_q + SUM_W'(signed'(rd_data_s1));
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_rsp_q.rect_sum    <= sum_q;
			out_rsp_q.range_error <= err_q;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rrs_check.sv
// Port-level checker for rectangle_range_sum, bound to the top level.
// Depends on rrs_pkg.
`default_nettype none

module rrs_check (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire rrs_pkg::req_t             in_req,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire rrs_pkg::rsp_t             out_rsp,
	input wire logic                      cfg_we,
	input wire logic                      cfg_index,
	input wire logic [rrs_pkg::CFG_W-1:0] cfg_data
);
	import rrs_pkg::*;

	// Hold a stalled response
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rsp))
		else $error("response changed while stalled");

	// An error response carries a zero sum
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.range_error |-> out_rsp.rect_sum == '0)
		else $error("range error with non-zero sum");

	// A query request keeps the input closed on the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req.op == OP_QUERY |=> !in_ready)
		else $error("request taken while a query is in progress");

	// A write request raises no response
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req.op == OP_WRITE && !out_valid |=> !out_valid)
		else $error("response after a write request");

	// Write registers only while the block is idle, with known index and data
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> in_ready && !out_valid && !$isunknown({cfg_index, cfg_data}))
		else $error("register written while a request is in flight");

endmodule

bind rectangle_range_sum rrs_check u_rrs_check (.*);

`default_nettype wire
